### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the box table search block.
// Depends on nothing; files that assert include it inside the module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form with an explicit clock and active-low reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Form for modules that use the standard clk_i and rst_ni names.
`define ASSERT_CLK(label, prop, msg) \
  `ASSERT_RST(label, clk_i, rst_ni, prop, msg)

`endif

### rtl/acts_pkg.sv
// Shared types and constants of the box table search block.
// Depends on nothing; used by the interfaces, acts_match and aabb_collision_table_search.
package acts_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned TAG_W   = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_BLOCK = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_WALL  = 2'd1,
    KIND_DOOR  = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  typedef struct packed {
    logic  active;
    kind_e kind;
    logic  dyn;
  } tag_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WRITE = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  typedef struct packed {
    logic start;
    logic eval;
  } scan_ctl_t;

  typedef struct packed {
    logic dyn_found;
    logic sta_found;
    logic blk_found;
  } match_stat_t;

endpackage

### rtl/acts_req_if.sv
// Request channel of the box table search block: valid, ready and payload.
// Depends on acts_pkg.
interface acts_req_if #(
  parameter int unsigned COORD_BITS = 16
) ();
  import acts_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             command;
  logic [INDEX_W-1:0]           index;
  logic                         active;
  logic [KIND_W-1:0]            kind;
  logic                         dynamic_group;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-2:0]        size_x;
  logic [COORD_BITS-2:0]        size_y;
  logic                         exclude_self;

  modport source (
    output valid, command, index, active, kind, dynamic_group,
    output pos_x, pos_y, size_x, size_y, exclude_self,
    input  ready
  );

  modport sink (
    input  valid, command, index, active, kind, dynamic_group,
    input  pos_x, pos_y, size_x, size_y, exclude_self,
    output ready
  );
endinterface

### rtl/acts_rsp_if.sv
// Response channel of the box table search block: valid, ready and payload.
// Depends on acts_pkg.
interface acts_rsp_if #(
  parameter int unsigned COORD_BITS = 16
) ();
  import acts_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [INDEX_W-1:0]           hit_index;
  logic [KIND_W-1:0]            hit_kind;
  logic                         hit_dynamic;
  logic signed [COORD_BITS-1:0] hit_pos_x;
  logic signed [COORD_BITS-1:0] hit_pos_y;
  logic [COORD_BITS-2:0]        hit_size_x;
  logic [COORD_BITS-2:0]        hit_size_y;

  modport source (
    output valid, hit, hit_index, hit_kind, hit_dynamic,
    output hit_pos_x, hit_pos_y, hit_size_x, hit_size_y,
    input  ready
  );

  modport sink (
    input  valid, hit, hit_index, hit_kind, hit_dynamic,
    input  hit_pos_x, hit_pos_y, hit_size_x, hit_size_y,
    output ready
  );
endinterface

### rtl/acts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module acts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/acts_match.sv
// Overlap test of one table entry against the query box, and tracking of the
// first dynamic hit, the first static hit and any wall or door hit. Uses acts_pkg.
module acts_match #(
  parameter int unsigned ADDR_W     = 6,
  parameter int unsigned COORD_BITS = 16,
  localparam int unsigned SIZE_W = COORD_BITS - 1,
  localparam int unsigned BOX_W  = 2 * COORD_BITS + 2 * SIZE_W,
  localparam int unsigned ENT_W  = acts_pkg::TAG_W + BOX_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  acts_pkg::scan_ctl_t            ctl_i,
  input  logic                           excl_i,
  input  logic [acts_pkg::INDEX_W-1:0]   self_idx_i,
  input  logic signed [COORD_BITS-1:0]   qry_px_i,
  input  logic signed [COORD_BITS-1:0]   qry_py_i,
  input  logic [SIZE_W-1:0]              qry_sx_i,
  input  logic [SIZE_W-1:0]              qry_sy_i,
  input  logic [ADDR_W-1:0]              entry_idx_i,
  input  logic [ENT_W-1:0]               entry_i,
  output acts_pkg::match_stat_t          stat_o,
  output logic [acts_pkg::INDEX_W-1:0]   hit_idx_o,
  output acts_pkg::tag_t                 hit_tag_o,
  output logic signed [COORD_BITS-1:0]   hit_px_o,
  output logic signed [COORD_BITS-1:0]   hit_py_o,
  output logic [SIZE_W-1:0]              hit_sx_o,
  output logic [SIZE_W-1:0]              hit_sy_o
);
  import acts_pkg::*;

  localparam int unsigned MAXW = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;

  tag_t                        e_tag;
  logic signed [COORD_BITS-1:0] e_px, e_py;
  logic [SIZE_W-1:0]           e_sx, e_sy;
  logic signed [COORD_BITS:0]  a_l, a_r, a_t, a_b;
  logic signed [COORD_BITS:0]  b_l, b_r, b_t, b_b;
  logic                        ovl, is_self, q_hit, take_dyn, take_sta, take_blk;
  logic [MAXW-1:0]             ent_ext;
  logic                        dyn_found_q, sta_found_q, blk_found_q;
  logic [ENT_W-1:0]            dyn_ent_q, sta_ent_q, sel_ent;
  logic [INDEX_W-1:0]          dyn_idx_q, sta_idx_q;

  assign e_tag = tag_t'(entry_i[ENT_W-1 -: TAG_W]);
  assign e_px  = entry_i[BOX_W-1 -: COORD_BITS];
  assign e_py  = entry_i[BOX_W-COORD_BITS-1 -: COORD_BITS];
  assign e_sx  = entry_i[2*SIZE_W-1 -: SIZE_W];
  assign e_sy  = entry_i[SIZE_W-1:0];

  // Edge sums are one bit wider than a coordinate, so they never wrap.
  assign a_l = {qry_px_i[COORD_BITS-1], qry_px_i};
  assign a_t = {qry_py_i[COORD_BITS-1], qry_py_i};
  assign a_r = a_l + signed'({2'b00, qry_sx_i});
  assign a_b = a_t + signed'({2'b00, qry_sy_i});
  assign b_l = {e_px[COORD_BITS-1], e_px};
  assign b_t = {e_py[COORD_BITS-1], e_py};
  assign b_r = b_l + signed'({2'b00, e_sx});
  assign b_b = b_t + signed'({2'b00, e_sy});

  assign ovl = (a_l < b_r) && (a_r > b_l) && (a_t < b_b) && (a_b > b_t);

  assign ent_ext = MAXW'(entry_idx_i);
  assign is_self = excl_i && (ent_ext == MAXW'(self_idx_i));
  assign q_hit   = e_tag.active && (e_tag.kind != KIND_NONE) && !is_self && ovl;

  assign take_dyn = ctl_i.eval && q_hit && e_tag.dyn && !dyn_found_q;
  assign take_sta = ctl_i.eval && q_hit && !e_tag.dyn && !sta_found_q;
  assign take_blk = ctl_i.eval && e_tag.active && ovl &&
                    ((e_tag.kind == KIND_WALL) || (e_tag.kind == KIND_DOOR));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_found_q <= 1'b0;
      sta_found_q <= 1'b0;
      blk_found_q <= 1'b0;
    end else if (ctl_i.start) begin
      dyn_found_q <= 1'b0;
      sta_found_q <= 1'b0;
      blk_found_q <= 1'b0;
    end else begin
      if (take_dyn) begin
        dyn_found_q <= 1'b1;
      end
      if (take_sta) begin
        sta_found_q <= 1'b1;
      end
      if (take_blk) begin
        blk_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_dyn) begin
      dyn_ent_q <= entry_i;
      dyn_idx_q <= ent_ext[INDEX_W-1:0];
    end
    if (take_sta) begin
      sta_ent_q <= entry_i;
      sta_idx_q <= ent_ext[INDEX_W-1:0];
    end
  end

  assign stat_o = '{dyn_found: dyn_found_q, sta_found: sta_found_q,
                    blk_found: blk_found_q};

  assign sel_ent   = dyn_found_q ? dyn_ent_q : sta_ent_q;
  assign hit_idx_o = dyn_found_q ? dyn_idx_q : sta_idx_q;
  assign hit_tag_o = tag_t'(sel_ent[ENT_W-1 -: TAG_W]);
  assign hit_px_o  = sel_ent[BOX_W-1 -: COORD_BITS];
  assign hit_py_o  = sel_ent[BOX_W-COORD_BITS-1 -: COORD_BITS];
  assign hit_sx_o  = sel_ent[2*SIZE_W-1 -: SIZE_W];
  assign hit_sy_o  = sel_ent[SIZE_W-1:0];

endmodule

### rtl/aabb_collision_table_search.sv
// Box table search: a table of TABLE_DEPTH axis-aligned boxes held in one
// synchronous memory, with first-collision and wall-or-door blocking queries.
// After reset the block sweeps the table once to mark every entry inactive,
// and takes no request during the sweep. A write goes through the write state
// and then the response state. A query reads one table entry per cycle from
// the single read port of the table memory; it ends early at the first dynamic
// hit, or for a blocking query at the first wall or door hit. One request is
// worked on at a time, and a new request is taken while the previous response
// waits.
// Depends on acts_pkg, acts_req_if, acts_rsp_if, acts_ram, acts_match.
module aabb_collision_table_search #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned COORD_BITS  = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  acts_req_if.sink  req_i,
  acts_rsp_if.source rsp_o
);
  import acts_pkg::*;

  localparam int unsigned AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MAXW   = (AW > INDEX_W) ? AW : INDEX_W;
  localparam int unsigned SIZE_W = COORD_BITS - 1;
  localparam int unsigned BOX_W  = 2 * COORD_BITS + 2 * SIZE_W;
  localparam int unsigned ENT_W  = TAG_W + BOX_W;

  state_e                       state_q, state_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  cmd_e                         cmd_q;
  logic [INDEX_W-1:0]           idx_q;
  logic                         excl_q;
  tag_t                         tag_q;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [SIZE_W-1:0]            sx_q, sy_q;
  logic                         rd_vld_q;
  logic [AW-1:0]                rd_idx_q;

  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [ENT_W-1:0]             ram_wdata, ram_rdata;

  logic                         req_acc, rsp_free, rsp_load;
  logic                         cnt_full, wr_in_range, scan_stop, scan_done;
  logic [MAXW-1:0]              idx_ext;

  scan_ctl_t                    scan_ctl;
  match_stat_t                  stat;
  logic [INDEX_W-1:0]           m_idx;
  tag_t                         m_tag;
  logic signed [COORD_BITS-1:0] m_px, m_py;
  logic [SIZE_W-1:0]            m_sx, m_sy;
  logic                         rsp_hit, rsp_fields;

  logic                         rsp_vld_q;
  logic                         hit_q;
  logic [INDEX_W-1:0]           hit_index_q;
  logic [KIND_W-1:0]            hit_kind_q;
  logic                         hit_dyn_q;
  logic signed [COORD_BITS-1:0] hit_px_q, hit_py_q;
  logic [SIZE_W-1:0]            hit_sx_q, hit_sy_q;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_vld_q || rsp_o.ready;

  assign idx_ext     = MAXW'(idx_q);
  assign wr_in_range = 32'(idx_q) < TABLE_DEPTH;
  assign cnt_full    = (cnt_q == CNT_W'(TABLE_DEPTH));
  assign scan_stop   = (cmd_q == CMD_QUERY) ? stat.dyn_found : stat.blk_found;
  assign scan_done   = scan_stop || (cnt_full && !rd_vld_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cnt_q[AW-1:0];
    ram_raddr = cnt_q[AW-1:0];
    ram_wdata = '0;
    rsp_load  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(TABLE_DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_acc) begin
          cnt_d = '0;
          unique case (cmd_e'(req_i.command)) inside
            CMD_WRITE:            state_d = ST_WRITE;
            CMD_QUERY, CMD_BLOCK: state_d = ST_SCAN;
            default:              state_d = ST_RESP;
          endcase
        end
      end
      ST_WRITE: begin
        ram_we    = wr_in_range;
        ram_waddr = idx_ext[AW-1:0];
        ram_wdata = {tag_q, px_q, py_q, sx_q, sy_q};
        state_d   = ST_RESP;
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_RESP;
        end else if (!cnt_full) begin
          ram_re = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
      end
      ST_RESP: begin
        if (rsp_free) begin
          rsp_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= ram_re;
      if (rsp_load) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cmd_q  <= cmd_e'(req_i.command);
      idx_q  <= req_i.index;
      excl_q <= req_i.exclude_self;
      tag_q  <= '{active: req_i.active, kind: kind_e'(req_i.kind),
                  dyn: req_i.dynamic_group};
      px_q   <= req_i.pos_x;
      py_q   <= req_i.pos_y;
      sx_q   <= req_i.size_x;
      sy_q   <= req_i.size_y;
    end
    rd_idx_q <= ram_raddr;
  end

  acts_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign scan_ctl = '{start: req_acc, eval: rd_vld_q && (state_q == ST_SCAN)};

  acts_match #(
    .ADDR_W     (AW),
    .COORD_BITS (COORD_BITS)
  ) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .excl_i      (excl_q),
    .self_idx_i  (idx_q),
    .qry_px_i    (px_q),
    .qry_py_i    (py_q),
    .qry_sx_i    (sx_q),
    .qry_sy_i    (sy_q),
    .entry_idx_i (rd_idx_q),
    .entry_i     (ram_rdata),
    .stat_o      (stat),
    .hit_idx_o   (m_idx),
    .hit_tag_o   (m_tag),
    .hit_px_o    (m_px),
    .hit_py_o    (m_py),
    .hit_sx_o    (m_sx),
    .hit_sy_o    (m_sy)
  );

  always_comb begin
    case (cmd_q)
      CMD_QUERY: rsp_hit = stat.dyn_found || stat.sta_found;
      CMD_BLOCK: rsp_hit = stat.blk_found;
      default:   rsp_hit = 1'b0;
    endcase
  end

  assign rsp_fields = (cmd_q == CMD_QUERY) && rsp_hit;

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      hit_q       <= rsp_hit;
      hit_index_q <= rsp_fields ? m_idx : '0;
      hit_kind_q  <= rsp_fields ? m_tag.kind : KIND_NONE;
      hit_dyn_q   <= rsp_fields && m_tag.dyn;
      hit_px_q    <= rsp_fields ? m_px : '0;
      hit_py_q    <= rsp_fields ? m_py : '0;
      hit_sx_q    <= rsp_fields ? m_sx : '0;
      hit_sy_q    <= rsp_fields ? m_sy : '0;
    end
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.hit         = hit_q;
  assign rsp_o.hit_index   = hit_index_q;
  assign rsp_o.hit_kind    = hit_kind_q;
  assign rsp_o.hit_dynamic = hit_dyn_q;
  assign rsp_o.hit_pos_x   = hit_px_q;
  assign rsp_o.hit_pos_y   = hit_py_q;
  assign rsp_o.hit_size_x  = hit_sx_q;
  assign rsp_o.hit_size_y  = hit_sy_q;

`include "assert_macros.svh"

  `ASSERT_CLK(a_table_one_access, !(ram_we && ram_re), "table read and written in one cycle")
  `ASSERT_CLK(a_read_in_table, ram_re |-> !cnt_full, "table read beyond its last entry")
  `ASSERT_CLK(a_rsp_from_resp, $rose(rsp_vld_q) |-> $past(state_q == ST_RESP), "stray response")

endmodule
